### hdl/pfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the pixel format to premultiplied RGBA
// converter.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int NUM_CH    = 3;  // red, green, blue
  localparam int DIV_STEPS = 8;  // quotient bits of the 16-bit scale
  localparam int DIV_IDX_W = 3;  // bits to index a quotient bit
  localparam int REM_W     = 24; // 16-bit channel times 255
  localparam int ACC_W     = 11; // sum of eight bytes

  localparam logic [1:0] FMT_32   = 2'd0;
  localparam logic [1:0] FMT_24   = 2'd1;
  localparam logic [1:0] FMT_16   = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  localparam logic [2:0] REG_FORMAT     = 3'd0;
  localparam logic [2:0] REG_RED_MASK   = 3'd1;
  localparam logic [2:0] REG_GREEN_MASK = 3'd2;
  localparam logic [2:0] REG_BLUE_MASK  = 3'd3;
  localparam logic [2:0] REG_ALPHA_MASK = 3'd4;
  localparam logic [2:0] REG_SRC_SHIFTS = 3'd5;
  localparam logic [2:0] REG_DST_SHIFTS = 3'd6;

  typedef struct packed {
    logic                           is16;
    logic [NUM_CH-1:0][REM_W-1:0]   rem;
    logic [NUM_CH-1:0][31:0]        dvs;
    logic [NUM_CH-1:0][7:0]         quo;
  } div_work_t;

  typedef struct packed {
    logic [NUM_CH-1:0][ACC_W-1:0]   acc;
    logic [NUM_CH-1:0][7:0]         low;
    logic [7:0]                     alpha8;
  } side_t;

endpackage

### hdl/pfr_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_div_stage
// One restoring division step for the three colour channels, registered.
// ----------------------------------------------------------------------------
module pfr_div_stage (
  input  logic                             clk,
  input  logic                             load,
  input  logic [pfr_pkg::DIV_IDX_W-1:0]    bit_index,
  input  pfr_pkg::div_work_t               d,
  output pfr_pkg::div_work_t               q
);

  logic [pfr_pkg::NUM_CH-1:0][39:0] den;
  logic [pfr_pkg::NUM_CH-1:0][39:0] num;
  pfr_pkg::div_work_t               nxt;

  always_comb begin
    nxt = d;
    for (int ch = 0; ch < pfr_pkg::NUM_CH; ch++) begin
      den[ch] = {8'b0, d.dvs[ch]} << bit_index;
      num[ch] = {16'b0, d.rem[ch]};
      if (num[ch] >= den[ch]) begin
        nxt.rem[ch] = d.rem[ch] - den[ch][pfr_pkg::REM_W-1:0];
        nxt.quo[ch] = d.quo[ch] | (8'd1 << bit_index);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= nxt;
    end
  end

endmodule

### hdl/pixel_format_to_rgba_premultiplied.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_to_rgba_premultiplied
// Converts raw 32/24/16-bit source pixels to packed, premultiplied RGBA.
// ----------------------------------------------------------------------------
// One source word in and one packed pixel out per clock while pix_stall is
// low, through extract, multiply, eight steps of the pipelined restoring
// divider that scales 16-bit channels, and the output register. The eight
// divider stages set the depth. Registers must be written through the APB
// port only while no pixel is in flight; the block does not enforce this.
// Every stage holds a valid bit and advances whenever the stage after it is
// empty or moving, so bubbles collapse under output stall.
// ----------------------------------------------------------------------------
module pixel_format_to_rgba_premultiplied (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [31:0] source_word,
  output logic        pix_valid,
  input  logic        pix_stall,
  output logic [31:0] packed_pixel
);

  localparam int NCH = pfr_pkg::NUM_CH;

  // configuration registers
  logic [1:0]  source_format;
  logic [31:0] red_field_mask;
  logic [31:0] green_field_mask;
  logic [31:0] blue_field_mask;
  logic [31:0] alpha_field_mask;
  logic [19:0] source_shifts;
  logic [19:0] dest_shifts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format    <= pfr_pkg::FMT_32;
      red_field_mask   <= 32'h0000_00FF;
      green_field_mask <= 32'h0000_FF00;
      blue_field_mask  <= 32'h00FF_0000;
      alpha_field_mask <= 32'hFF00_0000;
      source_shifts    <= 20'hC4100;
      dest_shifts      <= 20'hC4100;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        pfr_pkg::REG_FORMAT:     source_format    <= pwdata[1:0];
        pfr_pkg::REG_RED_MASK:   red_field_mask   <= pwdata;
        pfr_pkg::REG_GREEN_MASK: green_field_mask <= pwdata;
        pfr_pkg::REG_BLUE_MASK:  blue_field_mask  <= pwdata;
        pfr_pkg::REG_ALPHA_MASK: alpha_field_mask <= pwdata;
        pfr_pkg::REG_SRC_SHIFTS: source_shifts    <= pwdata[19:0];
        pfr_pkg::REG_DST_SHIFTS: dest_shifts      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pfr_pkg::REG_FORMAT:     prdata = {30'b0, source_format};
      pfr_pkg::REG_RED_MASK:   prdata = red_field_mask;
      pfr_pkg::REG_GREEN_MASK: prdata = green_field_mask;
      pfr_pkg::REG_BLUE_MASK:  prdata = blue_field_mask;
      pfr_pkg::REG_ALPHA_MASK: prdata = alpha_field_mask;
      pfr_pkg::REG_SRC_SHIFTS: prdata = {12'b0, source_shifts};
      pfr_pkg::REG_DST_SHIFTS: prdata = {12'b0, dest_shifts};
      default:                 prdata = 32'b0;
    endcase
  end

  // stage valids and flow control
  logic [11:1] v;
  logic [11:1] v_in;
  logic [12:1] rdy;

  assign rdy[12] = !pix_stall;
  for (genvar k = 1; k <= 11; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  assign v_in      = {v[10:1], src_valid};
  assign src_stall = !rdy[1];
  assign pix_valid = v[11];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (rdy[11:1] & v_in) | (~rdy[11:1] & v);
    end
  end

  // stage 1: extract channels
  logic [NCH-1:0][31:0] cmask;
  logic [NCH-1:0][4:0]  ssh;
  logic [31:0]          word_eff;
  logic [31:0]          a_full;
  logic                 use_alpha;
  logic [NCH-1:0][31:0] c_next;
  logic [NCH-1:0][31:0] dvs_next;

  logic [NCH-1:0][31:0] s1_c;
  logic [NCH-1:0][31:0] s1_dvs;
  logic [31:0]          s1_m;
  logic [7:0]           s1_a8;
  logic                 s1_is16;

  assign cmask = {blue_field_mask, green_field_mask, red_field_mask};
  assign ssh   = {source_shifts[14:10], source_shifts[9:5], source_shifts[4:0]};

  always_comb begin
    word_eff  = (source_format == pfr_pkg::FMT_16) ? {16'b0, source_word[15:0]}
                                                   : source_word;
    a_full    = (source_word & alpha_field_mask) >> source_shifts[19:15];
    use_alpha = (source_format == pfr_pkg::FMT_32) && (alpha_field_mask != 32'b0);
    for (int ch = 0; ch < NCH; ch++) begin
      c_next[ch]   = (word_eff & cmask[ch]) >> ssh[ch];
      dvs_next[ch] = cmask[ch] >> ssh[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_c    <= c_next;
      s1_dvs  <= dvs_next;
      s1_m    <= use_alpha ? a_full : 32'd255;
      s1_a8   <= use_alpha ? a_full[7:0] : 8'hFF;
      s1_is16 <= (source_format == pfr_pkg::FMT_16);
    end
  end

  // stage 2: products
  logic [NCH-1:0][63:0] s2_p;
  logic [NCH-1:0][31:0] s2_dvs;
  logic [7:0]           s2_a8;
  logic                 s2_is16;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        s2_p[ch] <= {32'b0, s1_c[ch]} * {32'b0, s1_m};
      end
      s2_dvs  <= s1_dvs;
      s2_a8   <= s1_a8;
      s2_is16 <= s1_is16;
    end
  end

  // stages 3..10: divider for the 16-bit scale
  pfr_pkg::div_work_t dw_head;
  pfr_pkg::div_work_t dw [3:10];

  always_comb begin
    dw_head.is16 = s2_is16;
    dw_head.dvs  = s2_dvs;
    dw_head.quo  = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      dw_head.rem[ch] = s2_p[ch][pfr_pkg::REM_W-1:0];
    end
  end

  for (genvar j = 0; j < pfr_pkg::DIV_STEPS; j++) begin : g_div
    pfr_pkg::div_work_t d_in;
    if (j == 0) begin : g_first
      assign d_in = dw_head;
    end else begin : g_rest
      assign d_in = dw[2+j];
    end
    pfr_div_stage u_step (
      .clk       (clk),
      .load      (rdy[3+j]),
      .bit_index (pfr_pkg::DIV_IDX_W'(pfr_pkg::DIV_STEPS - 1 - j)),
      .d         (d_in),
      .q         (dw[3+j])
    );
  end

  // stages 3..10: divide by 255 through byte sums (mod 255)
  pfr_pkg::side_t side [3:10];
  pfr_pkg::side_t side3_next;
  pfr_pkg::side_t side4_next;
  logic [NCH-1:0][8:0] fold;
  logic [NCH-1:0][8:0] rmod;

  always_comb begin
    side3_next.alpha8 = s2_a8;
    for (int ch = 0; ch < NCH; ch++) begin
      side3_next.acc[ch] = '0;
      for (int b = 0; b < 8; b++) begin
        side3_next.acc[ch] = side3_next.acc[ch]
                           + {3'b0, s2_p[ch][8*b +: 8]};
      end
      side3_next.low[ch] = s2_p[ch][7:0];
    end
  end

  always_comb begin
    side4_next = side[3];
    for (int ch = 0; ch < NCH; ch++) begin
      fold[ch] = {1'b0, side[3].acc[ch][7:0]} + {6'b0, side[3].acc[ch][10:8]};
      rmod[ch] = (fold[ch] >= 9'd255) ? fold[ch] - 9'd255 : fold[ch];
      // 255 = -1 mod 256, so low byte of the quotient is rem - low byte
      side4_next.low[ch] = rmod[ch][7:0] - side[3].low[ch];
    end
  end

  for (genvar k = 3; k <= 10; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        if (k == 3) begin
          side[k] <= side3_next;
        end else if (k == 4) begin
          side[k] <= side4_next;
        end else begin
          side[k] <= side[(k > 4) ? k - 1 : 4];
        end
      end
    end
  end

  // stage 11: pack
  logic [NCH-1:0][7:0] ch8;
  logic [NCH-1:0][4:0] dsh;
  logic [31:0]         pix_next;

  assign dsh = {dest_shifts[14:10], dest_shifts[9:5], dest_shifts[4:0]};

  always_comb begin
    pix_next = {24'b0, side[10].alpha8} << dest_shifts[19:15];
    for (int ch = 0; ch < NCH; ch++) begin
      if (source_format == pfr_pkg::FMT_16) begin
        ch8[ch] = (dw[10].dvs[ch] == 32'b0) ? 8'd0 : dw[10].quo[ch];
      end else begin
        ch8[ch] = side[10].low[ch];
      end
      pix_next = pix_next | ({24'b0, ch8[ch]} << dsh[ch]);
    end
    if (source_format == pfr_pkg::FMT_NONE) begin
      pix_next = 32'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      packed_pixel <= pix_next;
    end
  end

  // checks
  logic [NCH-1:0] rem_ok;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      rem_ok[ch] = !dw[10].is16 || (dw[10].dvs[ch] == 32'b0)
                || ({8'b0, dw[10].rem[ch]} < dw[10].dvs[ch]);
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    src_valid && !src_stall |=> v[1])
    else $error("accepted word did not enter stage 1");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    v[10] && rdy[11] |=> pix_valid)
    else $error("word lost between divider and output");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    v[10] |-> (&rem_ok))
    else $error("divider remainder not below divisor");

endmodule
